FILE: rtl/nrss_pkg.sv
// Shared types and constants for the nearest-request seek scheduler.
// No dependencies; every other file imports this package.
package nrss_pkg;

  localparam int DEF_ENTRIES       = 64;
  localparam int DEF_POSITION_BITS = 16;

  localparam int FIELD_POS_BITS = 16;
  localparam int TRACK_BITS     = 16;
  localparam int COUNT_BITS     = 16;
  localparam int SUM_BITS       = 32;
  localparam int STATUS_BITS    = 3;

  localparam int APB_ADDR_BITS = 3;
  localparam int APB_DATA_BITS = 32;

  localparam logic [TRACK_BITS-1:0] TRACK_RESET = 16'hFFFF;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX   = 16'hFFFF;

  // Register index, taken from paddr[2]
  localparam logic REG_TRACK_LENGTH = 1'b0;

  localparam logic KIND_ADD   = 1'b0;
  localparam logic KIND_SERVE = 1'b1;

  localparam logic [STATUS_BITS-1:0] STAT_ADDED  = 3'd0;
  localparam logic [STATUS_BITS-1:0] STAT_SERVED = 3'd1;
  localparam logic [STATUS_BITS-1:0] STAT_EMPTY  = 3'd2;
  localparam logic [STATUS_BITS-1:0] STAT_FULL   = 3'd3;
  localparam logic [STATUS_BITS-1:0] STAT_RANGE  = 3'd4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_INC,
    OP_NEW,
    OP_DEC
  } cmd_op_t;

  // Width-dependent structs shared by the controller and the cell row
  virtual class nrss_types #(parameter int POS_W = 16, parameter int IDX_W = 6);
    // Partial search record walking down the cell row
    typedef struct packed {
      logic             vld;
      logic             lo_hit;
      logic [POS_W-1:0] lo_pos;
      logic [IDX_W-1:0] lo_idx;
      logic             hi_hit;
      logic [POS_W-1:0] hi_pos;
      logic [IDX_W-1:0] hi_idx;
      logic             match_hit;
      logic [IDX_W-1:0] match_idx;
      logic             match_full;
      logic             free_hit;
      logic [IDX_W-1:0] free_idx;
    } scan_t;

    // Update broadcast to all cells
    typedef struct packed {
      cmd_op_t          op;
      logic [IDX_W-1:0] idx;
      logic [POS_W-1:0] pos;
    } cmd_t;
  endclass

endpackage

FILE: rtl/nrss_cell.sv
// One slot of the pending-request row: position, count, and one stage of the
// search record that moves to the next cell every cycle. Depends on nrss_pkg.
module nrss_cell
  import nrss_pkg::*;
#(
  parameter int ENTRIES       = DEF_ENTRIES,
  parameter int POSITION_BITS = DEF_POSITION_BITS
) (
  input  logic                                                   clk,
  input  logic                                                   rst_n,
  input  logic [$clog2(ENTRIES)-1:0]                             slot_idx,
  input  logic [POSITION_BITS-1:0]                               head,
  input  logic [POSITION_BITS-1:0]                               req_pos,
  input  nrss_types#(POSITION_BITS, $clog2(ENTRIES))::cmd_t      cmd,
  input  nrss_types#(POSITION_BITS, $clog2(ENTRIES))::scan_t     scan_in,
  output nrss_types#(POSITION_BITS, $clog2(ENTRIES))::scan_t     scan_out
);

  localparam int IDX_W = $clog2(ENTRIES);
  typedef nrss_types#(POSITION_BITS, IDX_W)::scan_t scan_t;

  logic [COUNT_BITS-1:0]    cnt_r, cnt_nxt;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  scan_t                    scan_r, scan_nxt;
  logic                     occupied;

  assign occupied = (cnt_r != '0);

  always_comb begin
    scan_nxt = scan_in;
    if (occupied) begin
      if (pos_r <= head && (!scan_in.lo_hit || pos_r > scan_in.lo_pos)) begin
        scan_nxt.lo_hit = 1'b1;
        scan_nxt.lo_pos = pos_r;
        scan_nxt.lo_idx = slot_idx;
      end
      if (pos_r >= head && (!scan_in.hi_hit || pos_r < scan_in.hi_pos)) begin
        scan_nxt.hi_hit = 1'b1;
        scan_nxt.hi_pos = pos_r;
        scan_nxt.hi_idx = slot_idx;
      end
      // Occupied positions are distinct, so at most one cell matches
      if (pos_r == req_pos) begin
        scan_nxt.match_hit  = 1'b1;
        scan_nxt.match_idx  = slot_idx;
        scan_nxt.match_full = (cnt_r == COUNT_MAX);
      end
    end else if (!scan_in.free_hit) begin
      scan_nxt.free_hit = 1'b1;
      scan_nxt.free_idx = slot_idx;
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    pos_nxt = pos_r;
    if (cmd.idx == slot_idx) begin
      unique case (cmd.op)
        OP_NONE: ;
        OP_INC:  cnt_nxt = cnt_r + COUNT_BITS'(1);
        OP_DEC:  cnt_nxt = cnt_r - COUNT_BITS'(1);
        OP_NEW: begin
          cnt_nxt = COUNT_BITS'(1);
          pos_nxt = cmd.pos;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      scan_r <= '0;
    end else begin
      cnt_r  <= cnt_nxt;
      scan_r <= scan_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
  end

  assign scan_out = scan_r;

endmodule

FILE: rtl/nrss_ctrl.sv
// Sequencer: takes a command, launches a search down the cell row, decides
// the outcome from the record at the row's end and drives the result.
// Depends on nrss_pkg.
module nrss_ctrl
  import nrss_pkg::*;
#(
  parameter int ENTRIES       = DEF_ENTRIES,
  parameter int POSITION_BITS = DEF_POSITION_BITS
) (
  input  logic                                               clk,
  input  logic                                               rst_n,
  input  logic                                               start,
  output logic                                               busy,
  input  logic                                               kind,
  input  logic [FIELD_POS_BITS-1:0]                          position,
  input  logic [TRACK_BITS-1:0]                              track_len,
  output logic                                               launch,
  output logic [POSITION_BITS-1:0]                           head,
  output logic [POSITION_BITS-1:0]                           req_pos,
  input  nrss_types#(POSITION_BITS, $clog2(ENTRIES))::scan_t chain_out,
  output nrss_types#(POSITION_BITS, $clog2(ENTRIES))::cmd_t  cmd,
  output logic                                               res_strobe,
  output logic [STATUS_BITS-1:0]                             res_status,
  output logic [FIELD_POS_BITS-1:0]                          res_head,
  output logic [FIELD_POS_BITS-1:0]                          res_moved,
  output logic [SUM_BITS-1:0]                                res_total,
  output logic                                               res_down
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CMP_W = (POSITION_BITS > TRACK_BITS) ? POSITION_BITS : TRACK_BITS;
  typedef nrss_types#(POSITION_BITS, IDX_W)::cmd_t cmd_t;

  state_t                   state_r, state_nxt;
  logic                     accept, decide, finish;
  logic                     launch_r;
  logic                     kind_r;
  logic [POSITION_BITS-1:0] pos_r;
  logic [POSITION_BITS-1:0] head_r;
  logic                     dir_r;
  logic [SUM_BITS-1:0]      sum_r, sum_nxt;
  logic [SUM_BITS:0]        sum_wide;
  logic [STATUS_BITS-1:0]   stat_r;
  logic [POSITION_BITS-1:0] moved_r;
  cmd_t                     cmd_r;

  logic                     out_strobe_r;
  logic [STATUS_BITS-1:0]   out_status_r;
  logic [FIELD_POS_BITS-1:0] out_head_r, out_moved_r;
  logic [SUM_BITS-1:0]      out_total_r;
  logic                     out_down_r;

  logic [STATUS_BITS-1:0]   dec_status;
  logic [POSITION_BITS-1:0] dec_head, dec_moved, ld, rd;
  logic                     dec_dir, take_lo, out_of_range;
  cmd_t                     dec_cmd;

  always_comb begin
    state_nxt = state_r;
    accept    = 1'b0;
    decide    = 1'b0;
    finish    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          accept    = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (chain_out.vld) begin
          decide    = 1'b1;
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        finish    = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign busy = (state_r != ST_IDLE);

  // Outcome of the item from the finished search record
  assign ld           = head_r - chain_out.lo_pos;
  assign rd           = chain_out.hi_pos - head_r;
  assign out_of_range = CMP_W'(pos_r) > CMP_W'(track_len);

  always_comb begin
    dec_status = STAT_EMPTY;
    dec_head   = head_r;
    dec_dir    = dir_r;
    dec_moved  = '0;
    dec_cmd    = '0;
    take_lo    = 1'b0;
    if (kind_r == KIND_ADD) begin
      priority if (out_of_range) begin
        dec_status = STAT_RANGE;
      end else if (chain_out.match_hit) begin
        if (chain_out.match_full) begin
          dec_status = STAT_FULL;
        end else begin
          dec_status  = STAT_ADDED;
          dec_cmd.op  = OP_INC;
          dec_cmd.idx = chain_out.match_idx;
        end
      end else if (chain_out.free_hit) begin
        dec_status  = STAT_ADDED;
        dec_cmd.op  = OP_NEW;
        dec_cmd.idx = chain_out.free_idx;
        dec_cmd.pos = pos_r;
      end else begin
        dec_status = STAT_FULL;
      end
    end else if (chain_out.lo_hit || chain_out.hi_hit) begin
      priority if (!chain_out.hi_hit) take_lo = 1'b1;
      else if (!chain_out.lo_hit)     take_lo = 1'b0;
      else if (ld < rd)               take_lo = 1'b1;
      else if (ld > rd)               take_lo = 1'b0;
      else                            take_lo = dir_r;
      // Keep the heading on a tie
      if (!chain_out.hi_hit || !chain_out.lo_hit || ld != rd) begin
        dec_dir = take_lo;
      end
      dec_status = STAT_SERVED;
      dec_cmd.op = OP_DEC;
      if (take_lo) begin
        dec_head    = chain_out.lo_pos;
        dec_moved   = ld;
        dec_cmd.idx = chain_out.lo_idx;
      end else begin
        dec_head    = chain_out.hi_pos;
        dec_moved   = rd;
        dec_cmd.idx = chain_out.hi_idx;
      end
    end
  end

  // Saturating running total
  assign sum_wide = {1'b0, sum_r} + (SUM_BITS + 1)'(moved_r);
  assign sum_nxt  = sum_wide[SUM_BITS] ? '1 : sum_wide[SUM_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      launch_r     <= 1'b0;
      cmd_r        <= '0;
      head_r       <= '0;
      dir_r        <= 1'b0;
      sum_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      launch_r     <= accept;
      cmd_r        <= decide ? dec_cmd : cmd_t'('0);
      out_strobe_r <= finish;
      if (decide) begin
        head_r <= dec_head;
        dir_r  <= dec_dir;
      end
      if (finish) begin
        sum_r <= sum_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= kind;
      pos_r  <= POSITION_BITS'(position);
    end
    if (decide) begin
      stat_r  <= dec_status;
      moved_r <= dec_moved;
    end
    if (finish) begin
      out_status_r <= stat_r;
      out_head_r   <= FIELD_POS_BITS'(head_r);
      out_moved_r  <= FIELD_POS_BITS'(moved_r);
      out_total_r  <= sum_nxt;
      out_down_r   <= dir_r;
    end
  end

  assign launch     = launch_r;
  assign head       = head_r;
  assign req_pos    = pos_r;
  assign cmd        = cmd_r;
  assign res_strobe = out_strobe_r;
  assign res_status = out_status_r;
  assign res_head   = out_head_r;
  assign res_moved  = out_moved_r;
  assign res_total  = out_total_r;
  assign res_down   = out_down_r;

endmodule

FILE: rtl/nearest_request_seek_scheduler.sv
// Nearest-request seek scheduler: a row of ENTRIES slots, each holding one
// distinct pending position and its request count, plus the head position,
// heading and a saturating distance total. A command (add or serve) is taken
// when start is high and busy is low; its one result is on the out_ ports for
// exactly one cycle with out_strobe high and cannot be held off. start is taken
// again in the cycle that carries the strobe; no new command is taken while one
// is in flight. The search record visits one slot per cycle as it moves down
// the row, then the controller decides the outcome and, in ST_FINISH, commits
// the update.
// The track_length register sits at byte address 0 of the APB port.
// Depends on nrss_pkg, nrss_cell and nrss_ctrl.
module nearest_request_seek_scheduler
  import nrss_pkg::*;
#(
  parameter int ENTRIES       = DEF_ENTRIES,
  parameter int POSITION_BITS = DEF_POSITION_BITS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic                      in_kind,
  input  logic [FIELD_POS_BITS-1:0] in_position,
  output logic                      out_strobe,
  output logic [STATUS_BITS-1:0]    out_status,
  output logic [FIELD_POS_BITS-1:0] out_head_position,
  output logic [FIELD_POS_BITS-1:0] out_moved_distance,
  output logic [SUM_BITS-1:0]       out_total_distance,
  output logic                      out_heading_down,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [APB_ADDR_BITS-1:0]  paddr,
  input  logic [APB_DATA_BITS-1:0]  pwdata,
  output logic [APB_DATA_BITS-1:0]  prdata,
  output logic                      pready
);

  localparam int IDX_W = $clog2(ENTRIES);
  typedef nrss_types#(POSITION_BITS, IDX_W)::scan_t scan_t;
  typedef nrss_types#(POSITION_BITS, IDX_W)::cmd_t  cmd_t;

  logic [TRACK_BITS-1:0]    track_r;
  logic                     reg_sel;
  logic                     launch;
  logic [POSITION_BITS-1:0] head, req_pos;
  cmd_t                     cmd;
  scan_t                    link [ENTRIES+1];

  // Configuration register
  assign reg_sel = (paddr[2] == REG_TRACK_LENGTH);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? APB_DATA_BITS'(track_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      track_r <= TRACK_RESET;
    end else if (psel && penable && pwrite && reg_sel) begin
      track_r <= pwdata[TRACK_BITS-1:0];
    end
  end

  // Seed an empty search record at the head of the row
  always_comb begin
    link[0]     = '0;
    link[0].vld = launch;
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_slot
    nrss_cell #(
      .ENTRIES       (ENTRIES),
      .POSITION_BITS (POSITION_BITS)
    ) u_slot (
      .clk      (clk),
      .rst_n    (rst_n),
      .slot_idx (IDX_W'(i)),
      .head     (head),
      .req_pos  (req_pos),
      .cmd      (cmd),
      .scan_in  (link[i]),
      .scan_out (link[i+1])
    );
  end

  nrss_ctrl #(
    .ENTRIES       (ENTRIES),
    .POSITION_BITS (POSITION_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .kind       (in_kind),
    .position   (in_position),
    .track_len  (track_r),
    .launch     (launch),
    .head       (head),
    .req_pos    (req_pos),
    .chain_out  (link[ENTRIES]),
    .cmd        (cmd),
    .res_strobe (out_strobe),
    .res_status (out_status),
    .res_head   (out_head_position),
    .res_moved  (out_moved_distance),
    .res_total  (out_total_distance),
    .res_down   (out_heading_down)
  );

endmodule
